// File: hdl/dedq_pkg.sv
`timescale 1ns / 1ps
// Package for the double-ended queue: command codes and payload types.
// Depends on nothing; dedq_if, dedq_ptr, the top level and the checker use it.

package dedq_pkg;

   // Widths of the request and response payload fields.
   localparam int DATA_W  = 32;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 11;

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic signed [DATA_W-1:0]  data_type;
   typedef logic [COUNT_W-1:0]        count_type;

   // Command codes.
   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_PEEK_FRONT = 3'd4;
   localparam cmd_type CMD_PEEK_BACK  = 3'd5;

   // Decoded outcome of one request, passed from the pointer logic to the top level.
   typedef struct packed {
      logic write_en;
      logic read_en;
      logic overflow;
   } ptr_status_type;

endpackage

// File: hdl/dedq_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the request and response channels of the queue.
// Depends on dedq_pkg for the payload types.

interface dedq_req_if;
   logic               valid;
   logic               ready;
   dedq_pkg::cmd_type  cmd;
   dedq_pkg::data_type push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);
   modport mon    (input valid, input cmd, input push_value, input ready);
endinterface

interface dedq_rsp_if;
   logic                valid;
   logic                ready;
   dedq_pkg::data_type  data_value;
   logic                data_valid;
   dedq_pkg::count_type element_count;
   logic                is_empty;
   logic                overflow;

   modport source (output valid, output data_value, output data_valid,
                   output element_count, output is_empty, output overflow,
                   input ready);
   modport sink   (input valid, input data_value, input data_valid,
                   input element_count, input is_empty, input overflow,
                   output ready);
   modport mon    (input valid, input data_value, input data_valid,
                   input element_count, input is_empty, input overflow,
                   input ready);
endinterface

// File: hdl/dedq_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; depends on no package.

module dedq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: hdl/dedq_ptr.sv
`timescale 1ns / 1ps
// Head pointer and fill count of the ring buffer, and the slot each request touches.
// Depends on dedq_pkg for command codes and the status struct.

module dedq_ptr #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  dedq_pkg::cmd_type            cmd,
   output logic [$clog2(DEPTH)-1:0]     mem_addr,
   output dedq_pkg::ptr_status_type     status,
   output logic [$clog2(DEPTH+1)-1:0]   count_next
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] cnt_type;
   typedef logic [AW:0]   sum_type;

   addr_type head_ff, head_in;
   cnt_type  count_ff, count_in;
   addr_type head_inc, head_dec, tail_slot, last_slot;
   logic     full, empty;

   // Slot at a given distance past the head, wrapped once at DEPTH.
   function automatic addr_type slot_at(addr_type head, cnt_type offset);
      sum_type sum;
      sum = {1'b0, head} + sum_type'(offset);
      if (sum >= sum_type'(DEPTH)) begin
         sum = sum - sum_type'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Neighbouring slots of the head and the two ends of the stored range.
   always_comb begin
      full      = (count_ff == cnt_type'(DEPTH));
      empty     = (count_ff == '0);
      head_inc  = (head_ff == addr_type'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      head_dec  = (head_ff == '0) ? addr_type'(DEPTH - 1) : head_ff - 1'b1;
      tail_slot = slot_at(head_ff, count_ff);
      last_slot = slot_at(head_ff, cnt_type'(count_ff - 1'b1));
   end

   // Decode the request into a memory access and the next pointer state.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      mem_addr = head_ff;
      status   = '0;
      unique case (cmd) inside
         dedq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               status.overflow = 1'b1;
            end else begin
               head_in         = head_dec;
               mem_addr        = head_dec;
               status.write_en = 1'b1;
               count_in        = count_ff + 1'b1;
            end
         end
         dedq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               status.overflow = 1'b1;
            end else begin
               mem_addr        = tail_slot;
               status.write_en = 1'b1;
               count_in        = count_ff + 1'b1;
            end
         end
         dedq_pkg::CMD_POP_FRONT, dedq_pkg::CMD_PEEK_FRONT: begin
            if (!empty) begin
               mem_addr       = head_ff;
               status.read_en = 1'b1;
               if (cmd == dedq_pkg::CMD_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dedq_pkg::CMD_POP_BACK, dedq_pkg::CMD_PEEK_BACK: begin
            if (!empty) begin
               mem_addr       = last_slot;
               status.read_en = 1'b1;
               if (cmd == dedq_pkg::CMD_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            // Unused codes leave the queue as it is.
         end
      endcase
      count_next = count_in;
   end

   // Pointer registers change only when a request is taken, or on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// A push, an unused code or a pop or peek of an empty queue is answered in the cycle after
// acceptance; a pop or peek that reads a stored word passes through ST_READ first.
// Throughput: one request per cycle while responses are taken; a memory read holds off the next request in ST_READ.
// Reset clears the state, the head pointer, the fill count and the response valid flag; the word memory
// keeps its contents, since every slot is written before it is read.
// Depends on dedq_pkg, dedq_if, dedq_ram and dedq_ptr.

module double_ended_queue_top #(
   parameter int DEPTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   dedq_req_if.sink      req_chan,
   dedq_rsp_if.source    rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                          state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;
   logic [AW-1:0]                 mem_addr;
   logic [CW-1:0]                 count_next;
   dedq_pkg::ptr_status_type      status;
   logic [dedq_pkg::DATA_W-1:0]   rd_data;

   dedq_pkg::data_type            data_ff;
   logic                          data_valid_ff;
   dedq_pkg::count_type           count_ff;
   logic                          empty_ff;
   logic                          overflow_ff;

   // A request is taken when no read is in flight and the response slot is free.
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   dedq_ptr #(
      .DEPTH (DEPTH)
   ) u_ptr (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_chan.cmd),
      .mem_addr   (mem_addr),
      .status     (status),
      .count_next (count_next)
   );

   dedq_ram #(
      .WIDTH (dedq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && status.write_en),
      .wr_addr (mem_addr),
      .wr_data (req_chan.push_value),
      .rd_en   (accept && status.read_en),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   // Control: a memory read waits in ST_READ for the word, then presents the response; other requests skip ST_READ.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.read_en) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: status at acceptance, memory word in the ST_READ state.
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff       <= '0;
         data_valid_ff <= status.read_en;
         count_ff      <= dedq_pkg::count_type'(count_next);
         empty_ff      <= (count_next == '0);
         overflow_ff   <= status.overflow;
      end else if (state_ff == ST_READ) begin
         data_ff <= dedq_pkg::data_type'(rd_data);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_value    = data_ff;
   assign rsp_chan.data_valid    = data_valid_ff;
   assign rsp_chan.element_count = count_ff;
   assign rsp_chan.is_empty      = empty_ff;
   assign rsp_chan.overflow      = overflow_ff;

endmodule

// File: hdl/dedq_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dedq_pkg for the payload types.

module dedq_chk (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input dedq_pkg::data_type  rsp_data_value,
   input logic                rsp_data_valid,
   input dedq_pkg::count_type rsp_element_count,
   input logic                rsp_is_empty,
   input logic                rsp_overflow
);

   // No response may be pending in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // The empty flag agrees with the element count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_element_count == '0)))
      else $error("empty flag disagrees with element count");

   // A dropped push returns no word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_data_valid)
      else $error("overflow response carries a word");

   // With no word returned the data field is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |-> (rsp_data_value == '0))
      else $error("data nonzero without a returned word");

   // A stalled response keeps its count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_count))
      else $error("stalled response changed");

endmodule

bind double_ended_queue_top dedq_chk u_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_data_value    (rsp_chan.data_value),
   .rsp_data_valid    (rsp_chan.data_valid),
   .rsp_element_count (rsp_chan.element_count),
   .rsp_is_empty      (rsp_chan.is_empty),
   .rsp_overflow      (rsp_chan.overflow)
);
